// ----- rtl/core/rwmf_pkg.sv -----
// Shared types and constants for the RGB window median filter.
`default_nettype none
package rwmf_pkg;

  localparam int PIX_W = 24;   // packed red, green, blue
  localparam int CH_W  = 8;
  localparam int ROW_W = 16;
  localparam int COL_W = 11;
  localparam int WID_W = 12;
  localparam int RAD_W = 2;
  localparam int WIN_W = 3;    // window row or column index, side up to 7
  localparam int CNT_W = 6;    // element count, up to 49
  localparam int BIT_W = 3;    // bit position within a channel

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  typedef struct packed {
    logic             start;   // new window: clear the running answer
    logic             dvalid;  // read data valid this cycle
    logic             dlast;   // last element of the current pass
    logic [BIT_W-1:0] bitpos;  // bit decided in this pass
  } sel_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/core/rwmf_line_store.sv -----
// Line store: single write port, single registered read port.
`default_nettype none
module rwmf_line_store #(
  parameter int DEPTH = 14336,
  parameter int AW    = 14
) (
  input  wire logic                         clk,
  input  wire logic                         we,
  input  wire logic [AW-1:0]                waddr,
  input  wire logic [rwmf_pkg::PIX_W-1:0]   wdata,
  input  wire logic [AW-1:0]                raddr,
  output logic      [rwmf_pkg::PIX_W-1:0]   rdata
);

  logic [rwmf_pkg::PIX_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ----- rtl/core/rwmf_select.sv -----
// Bitwise rank selection over a streamed window, three channels in parallel.
`default_nettype none
module rwmf_select (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire rwmf_pkg::sel_ctl_t           ctl,
  input  wire logic [rwmf_pkg::CNT_W-1:0]   rank,
  input  wire logic [rwmf_pkg::PIX_W-1:0]   rdata,
  output logic      [rwmf_pkg::PIX_W-1:0]   median
);

  for (genvar g = 0; g < 3; g++) begin : g_ch
    logic [rwmf_pkg::CH_W-1:0]  ans_r;
    logic [rwmf_pkg::CNT_W-1:0] cnt_r;
    logic [rwmf_pkg::CH_W-1:0]  cand;
    logic [rwmf_pkg::CH_W-1:0]  val;
    logic [rwmf_pkg::CNT_W-1:0] cnt_sum;

    assign val     = rdata[g*rwmf_pkg::CH_W +: rwmf_pkg::CH_W];
    assign cand    = ans_r | (rwmf_pkg::CH_W'(1) << ctl.bitpos);
    assign cnt_sum = cnt_r + rwmf_pkg::CNT_W'(val < cand);

    // answer keeps candidate bit when no more than rank elements lie below it
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        cnt_r <= '0;
        ans_r <= '0;
      end else if (ctl.start) begin
        cnt_r <= '0;
        ans_r <= '0;
      end else if (ctl.dvalid) begin
        if (ctl.dlast) begin
          cnt_r <= '0;
          if (cnt_sum <= rank) begin
            ans_r <= cand;
          end
        end else begin
          cnt_r <= cnt_sum;
        end
      end
    end

    assign median[g*rwmf_pkg::CH_W +: rwmf_pkg::CH_W] = ans_r;
  end

endmodule
`default_nettype wire

// ----- rtl/core/rgb_window_median_filter.sv -----
// Streaming per-channel RGB median filter over a square window of side
// 2*R+1. Each pixel is written once into a line store of 2*MAX_RADIUS+1 rows.
// Border pixels (closer than R to an edge) are copied out through the output
// register; when a pixel completes the bottom-right of an interior window,
// the window median comes out first, with the row and column of its center.
// The median is found bit by bit: eight passes over the window, each pass
// reading one stored pixel per cycle from the line store read port, and a
// wait state after each pass; a pixel that only borders goes through the
// border state, and one with no result returns straight to idle.
// One pixel is in work at a time; a new transaction is taken as soon as the
// last result is in the output register, even while that result waits.
// The line store is not cleared; its contents are valid once rows are filled.
`default_nettype none
module rgb_window_median_filter #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_RADIUS = 3
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // pixel input
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_red,
  input  wire logic [7:0]  in_green,
  input  wire logic [7:0]  in_blue,
  input  wire logic        in_frame_start,
  // result output
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [15:0]      out_row,
  output logic [10:0]      out_col,
  output logic             out_run_last,
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 1;
  localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
  localparam int AW        = $clog2(DEPTH);
  localparam int SW        = $clog2(LINE_ROWS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_WAIT = 3'd2;
  localparam logic [2:0] ST_MED  = 3'd3;
  localparam logic [2:0] ST_BRD  = 3'd4;

  // configuration registers
  logic [rwmf_pkg::WID_W-1:0] width_r;
  logic [rwmf_pkg::ROW_W-1:0] height_r;
  logic [rwmf_pkg::RAD_W-1:0] radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 16'd480;
      radius_r <= 2'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        rwmf_pkg::REG_WIDTH:  width_r  <= cfg_data[rwmf_pkg::WID_W-1:0];
        rwmf_pkg::REG_HEIGHT: height_r <= cfg_data;
        rwmf_pkg::REG_RADIUS: radius_r <= cfg_data[rwmf_pkg::RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // effective geometry: zero acts as one, width and radius saturate
  logic [rwmf_pkg::WID_W-1:0] w_eff;
  logic [rwmf_pkg::ROW_W-1:0] h_eff;
  logic [rwmf_pkg::RAD_W-1:0] rad;
  logic [rwmf_pkg::WIN_W-1:0] rad2;
  logic [rwmf_pkg::WIN_W-1:0] side;

  assign w_eff = (width_r == '0) ? rwmf_pkg::WID_W'(1) :
                 (int'(width_r) > MAX_WIDTH) ? rwmf_pkg::WID_W'(MAX_WIDTH) : width_r;
  assign h_eff = (height_r == '0) ? rwmf_pkg::ROW_W'(1) : height_r;
  assign rad   = (int'(radius_r) > MAX_RADIUS) ? rwmf_pkg::RAD_W'(MAX_RADIUS) : radius_r;
  assign rad2  = {rad, 1'b0};
  assign side  = rad2 + rwmf_pkg::WIN_W'(1);

  // state
  logic [2:0]                  state_r, state_nxt;
  logic [rwmf_pkg::ROW_W-1:0]  row_count_r;
  logic [rwmf_pkg::COL_W-1:0]  col_count_r;
  logic [SW-1:0]               slot_r;        // row_count mod LINE_ROWS
  logic [rwmf_pkg::PIX_W-1:0]  pix_r;
  logic [rwmf_pkg::ROW_W-1:0]  row_r;
  logic [rwmf_pkg::COL_W-1:0]  col_r;
  logic                        med_r, brd_r;
  logic [SW-1:0]               win_slot_r, slot_cur_r;
  logic [rwmf_pkg::COL_W-1:0]  col0_r;
  logic [rwmf_pkg::WIN_W-1:0]  wi_r, wj_r, side_r;
  logic [rwmf_pkg::BIT_W-1:0]  bit_r;
  logic [rwmf_pkg::CNT_W-1:0]  rank_r;
  logic [rwmf_pkg::RAD_W-1:0]  rad_r;
  logic                        rd_valid_r, rd_last_r;

  // accept-time decode
  logic                        accept;
  logic [rwmf_pkg::ROW_W-1:0]  row_in;
  logic [rwmf_pkg::COL_W-1:0]  col_raw, col_in;
  logic [SW-1:0]               slot_in, win_slot;
  logic                        is_med, is_brd, col_wrap, row_wrap;
  logic [AW-1:0]               waddr;
  logic [rwmf_pkg::PIX_W-1:0]  pix_in;
  int                          s_tmp;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pix_in   = {in_red, in_green, in_blue};
  assign row_in   = in_frame_start ? '0 : row_count_r;
  assign col_raw  = in_frame_start ? '0 : col_count_r;
  assign slot_in  = in_frame_start ? '0 : slot_r;
  // column past the width is held on the last column
  assign col_in   = ({1'b0, col_raw} >= w_eff) ?
                    rwmf_pkg::COL_W'(w_eff - rwmf_pkg::WID_W'(1)) : col_raw;
  assign waddr    = AW'(int'(slot_in) * MAX_WIDTH + int'(col_in));

  assign is_med = (row_in >= rwmf_pkg::ROW_W'(rad2)) && (col_in >= rwmf_pkg::COL_W'(rad2));
  assign is_brd = (row_in < rwmf_pkg::ROW_W'(rad)) ||
                  ({1'b0, row_in} + 17'(rad) >= {1'b0, h_eff}) ||
                  (col_in < rwmf_pkg::COL_W'(rad)) ||
                  ({1'b0, col_in} + rwmf_pkg::WID_W'(rad) >= w_eff);

  // line slot of the window's top row
  assign s_tmp    = int'(slot_in) + LINE_ROWS - int'(rad2);
  assign win_slot = (s_tmp >= LINE_ROWS) ? SW'(s_tmp - LINE_ROWS) : SW'(s_tmp);

  assign col_wrap = ({1'b0, col_raw} + rwmf_pkg::WID_W'(1)) >= w_eff;
  assign row_wrap = ({1'b0, row_in} + 17'd1) >= {1'b0, h_eff};

  // window scan addressing
  logic [AW-1:0] raddr;
  logic          issue_last, row_end;
  logic [SW-1:0] slot_inc;

  assign raddr      = AW'(int'(slot_cur_r) * MAX_WIDTH + int'(col0_r) + int'(wj_r));
  assign row_end    = (wj_r == side_r - rwmf_pkg::WIN_W'(1));
  assign issue_last = row_end && (wi_r == side_r - rwmf_pkg::WIN_W'(1));
  assign slot_inc   = (int'(slot_cur_r) == LINE_ROWS - 1) ? '0 : slot_cur_r + SW'(1);

  // output register
  logic                        out_free, out_load;
  logic [rwmf_pkg::PIX_W-1:0]  median;

  assign out_free = !out_valid || out_ready;
  assign out_load = out_free && (state_r == ST_MED || state_r == ST_BRD);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = is_med ? ST_SCAN : (is_brd ? ST_BRD : ST_IDLE);
        end
      end
      ST_SCAN: if (issue_last) state_nxt = ST_WAIT;
      ST_WAIT: state_nxt = (bit_r == '0) ? ST_MED : ST_SCAN;
      ST_MED:  if (out_free) state_nxt = brd_r ? ST_BRD : ST_IDLE;
      ST_BRD:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      row_count_r <= '0;
      col_count_r <= '0;
      slot_r      <= '0;
      rd_valid_r  <= 1'b0;
      rd_last_r   <= 1'b0;
      med_r       <= 1'b0;
      brd_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      rd_valid_r <= (state_r == ST_SCAN);
      rd_last_r  <= (state_r == ST_SCAN) && issue_last;
      if (accept) begin
        med_r <= is_med;
        brd_r <= is_brd;
        if (col_wrap) begin
          col_count_r <= '0;
          if (row_wrap) begin
            row_count_r <= '0;
            slot_r      <= '0;
          end else begin
            row_count_r <= row_in + rwmf_pkg::ROW_W'(1);
            slot_r      <= (int'(slot_in) == LINE_ROWS - 1) ? '0 : slot_in + SW'(1);
          end
        end else begin
          col_count_r <= col_raw + rwmf_pkg::COL_W'(1);
          row_count_r <= row_in;
          slot_r      <= slot_in;
        end
      end
    end
  end

  // per-item payload and scan counters
  always_ff @(posedge clk) begin
    if (accept) begin
      pix_r      <= pix_in;
      row_r      <= row_in;
      col_r      <= col_in;
      rad_r      <= rad;
      side_r     <= side;
      rank_r     <= rwmf_pkg::CNT_W'((int'(side) * int'(side)) / 2);
      win_slot_r <= win_slot;
      slot_cur_r <= win_slot;
      col0_r     <= col_in - rwmf_pkg::COL_W'(rad2);
      wi_r       <= '0;
      wj_r       <= '0;
      bit_r      <= rwmf_pkg::BIT_W'(rwmf_pkg::CH_W - 1);
    end else if (state_r == ST_SCAN) begin
      if (row_end) begin
        wj_r       <= '0;
        wi_r       <= wi_r + rwmf_pkg::WIN_W'(1);
        slot_cur_r <= slot_inc;
      end else begin
        wj_r <= wj_r + rwmf_pkg::WIN_W'(1);
      end
    end else if (state_r == ST_WAIT) begin
      // next bit pass restarts the window walk
      bit_r      <= bit_r - rwmf_pkg::BIT_W'(1);
      wi_r       <= '0;
      wj_r       <= '0;
      slot_cur_r <= win_slot_r;
    end
  end

  logic [rwmf_pkg::PIX_W-1:0] rdata;

  rwmf_line_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (accept),
    .waddr (waddr),
    .wdata (pix_in),
    .raddr (raddr),
    .rdata (rdata)
  );

  rwmf_pkg::sel_ctl_t sel_ctl;

  assign sel_ctl.start  = accept;
  assign sel_ctl.dvalid = rd_valid_r;
  assign sel_ctl.dlast  = rd_last_r;
  assign sel_ctl.bitpos = bit_r;

  rwmf_select u_select (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (sel_ctl),
    .rank   (rank_r),
    .rdata  (rdata),
    .median (median)
  );

  // output stage: median first, border copy second
  logic                       out_valid_r;
  logic [rwmf_pkg::PIX_W-1:0] out_pix_r;
  logic [rwmf_pkg::ROW_W-1:0] out_row_r;
  logic [rwmf_pkg::COL_W-1:0] out_col_r;
  logic                       out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (state_r == ST_MED) begin
        out_pix_r  <= median;
        out_row_r  <= row_r - rwmf_pkg::ROW_W'(rad_r);
        out_col_r  <= col_r - rwmf_pkg::COL_W'(rad_r);
        out_last_r <= !brd_r;
      end else begin
        out_pix_r  <= pix_r;
        out_row_r  <= row_r;
        out_col_r  <= col_r;
        out_last_r <= 1'b1;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_pix_r[23:16];
  assign out_green    = out_pix_r[15:8];
  assign out_blue     = out_pix_r[7:0];
  assign out_row      = out_row_r;
  assign out_col      = out_col_r;
  assign out_run_last = out_last_r;

  // the wait cycle always consumes the last read of a pass
  a_wait_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_WAIT) |-> (rd_valid_r && rd_last_r))
    else $error("pass end without last read data");

  // a transaction with no result returns straight to idle
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((state_r == ST_IDLE) == (!med_r && !brd_r)))
    else $error("post-accept state does not match result flags");

  // scan counters stay inside the window
  a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (wi_r < side_r && wj_r < side_r))
    else $error("window scan index out of range");

  // a loaded median is never the last result when a border copy follows
  a_med_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && state_r == ST_MED && brd_r) |=> (state_r == ST_BRD && !out_last_r))
    else $error("median/border ordering broken");

endmodule
`default_nettype wire

// ----- verif/rgb_window_median_filter_tb.sv -----
// Self-checking testbench for the streaming RGB window median filter.
`timescale 1ns / 1ps
`default_nettype none
module rgb_window_median_filter_tb;

  localparam int LROWS    = 7;       // line store rows (2*MAX_RADIUS+1)
  localparam int MAXW     = 2048;
  localparam int WDOG_MAX = 20000;   // cycles with no transaction at all
  localparam int SETTLE   = 40;      // a pixel with no result may still be in work

  typedef struct {
    logic [7:0] r, g, b;
    logic       fs;
  } pixel_t;

  typedef struct {
    logic [7:0]  r, g, b;
    logic [15:0] row;
    logic [10:0] col;
    logic        last;
  } outpix_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red = '0, in_green = '0, in_blue = '0;
  logic        in_frame_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red, out_green, out_blue;
  logic [15:0] out_row;
  logic [10:0] out_col;
  logic        out_run_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = rwmf_pkg::REG_WIDTH;
  logic [15:0] cfg_data = '0;

  rgb_window_median_filter dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------- predictor state ----------------
  logic [23:0] line_mem [LROWS][MAXW];
  logic [15:0] row_cnt;
  logic [10:0] col_cnt;
  logic [11:0] width_reg  = 12'd640;
  logic [15:0] height_reg = 16'd480;
  logic [1:0]  radius_reg = 2'd1;

  pixel_t  pixel_q[$];
  outpix_t filtered_q[$];   // expected output pixels, oldest first

  int errors = 0;
  int n_pixels = 0, n_results = 0, n_medians = 0;
  int idle_mode = 0;        // 0 none, 1 sender 70%, 2 receiver 70%, 3 both 13%
  bit hold_req = 0, hold_taken = 0;
  int hold_left = 0;
  int wdog = 0;

  task automatic report(input string what, input int got, input int want);
    errors++;
    $display("mismatch @%0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic [7:0] median_of(input logic [7:0] v[49], input int n);
    logic [7:0] s[49];
    logic [7:0] x;
    int j;
    for (int i = 0; i < n; i++) begin
      x = v[i];
      j = i;
      while (j > 0 && s[j-1] > x) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = x;
    end
    return s[n/2];
  endfunction

  // Work out the output pixels one input transaction causes.
  task automatic filter_pixel(input pixel_t p);
    int w, h, rad, side, row, col, cnt, rr, cc;
    logic [7:0] vr[49], vg[49], vb[49];
    logic [23:0] px, wpx;
    outpix_t o;
    bit any;
    w = (width_reg == 0) ? 1 : (width_reg > MAXW ? MAXW : int'(width_reg));
    h = (height_reg == 0) ? 1 : int'(height_reg);
    rad = int'(radius_reg);
    side = 2 * rad + 1;
    any = 0;
    if (p.fs) begin
      row_cnt = '0;
      col_cnt = '0;
    end
    row = int'(row_cnt);
    col = int'(col_cnt);
    if (col >= w) col = w - 1;
    px = {p.r, p.g, p.b};
    line_mem[row % LROWS][col] = px;
    if (row >= 2 * rad && col >= 2 * rad) begin
      cnt = 0;
      for (int i = 0; i < side; i++) begin
        rr = row - 2 * rad + i;
        for (int k = 0; k < side; k++) begin
          cc = col - 2 * rad + k;
          wpx = line_mem[rr % LROWS][cc];
          {vr[cnt], vg[cnt], vb[cnt]} = wpx;
          cnt++;
        end
      end
      o.r = median_of(vr, cnt);
      o.g = median_of(vg, cnt);
      o.b = median_of(vb, cnt);
      o.row = 16'(row - rad);
      o.col = 11'(col - rad);
      o.last = 0;
      filtered_q.push_back(o);
      n_medians++;
      any = 1;
    end
    if (row < rad || row + rad >= h || col < rad || col + rad >= w) begin
      o.r = p.r; o.g = p.g; o.b = p.b;
      o.row = 16'(row);
      o.col = 11'(col);
      o.last = 0;
      filtered_q.push_back(o);
      any = 1;
    end
    if (any) filtered_q[$].last = 1;
    if (int'(col_cnt) + 1 >= w) begin
      col_cnt = '0;
      row_cnt = (int'(row_cnt) + 1 >= h) ? 16'd0 : row_cnt + 16'd1;
    end else begin
      col_cnt = col_cnt + 11'd1;
    end
  endtask

  // ---------------- pixel driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (pixel_q.size() > 0 &&
          !((idle_mode == 1 && $urandom_range(99) < 70) ||
            (idle_mode == 3 && $urandom_range(99) < 13))) begin
        pixel_t p;
        p = pixel_q.pop_front();
        in_valid       <= 1'b1;
        in_red         <= p.r;
        in_green       <= p.g;
        in_blue        <= p.b;
        in_frame_start <= p.fs;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver: random stalls and one long hold-off ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_taken) begin
      hold_taken <= 1;
      hold_left  <= 600;
      out_ready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !((idle_mode == 2 && $urandom_range(99) < 70) ||
                     (idle_mode == 3 && $urandom_range(99) < 13));
    end
  end

  // ---------------- monitor: predict on input, check on output ----------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          rwmf_pkg::REG_WIDTH:  width_reg  = cfg_data[11:0];
          rwmf_pkg::REG_HEIGHT: height_reg = cfg_data;
          rwmf_pkg::REG_RADIUS: radius_reg = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        pixel_t p;
        p.r = in_red; p.g = in_green; p.b = in_blue; p.fs = in_frame_start;
        filter_pixel(p);
        n_pixels++;
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (filtered_q.size() == 0) begin
          report("unexpected result, row", out_row, -1);
        end else begin
          outpix_t e;
          e = filtered_q.pop_front();
          if (out_red      !== e.r)    report("out_red", out_red, e.r);
          if (out_green    !== e.g)    report("out_green", out_green, e.g);
          if (out_blue     !== e.b)    report("out_blue", out_blue, e.b);
          if (out_row      !== e.row)  report("out_row", out_row, e.row);
          if (out_col      !== e.col)  report("out_col", out_col, e.col);
          if (out_run_last !== e.last) report("out_run_last", out_run_last, e.last);
        end
      end
    end
  end

  // watchdog: cycles in which no transaction of any kind happens
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      wdog <= 0;
    else
      wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("[rgb_window_median_filter] ERROR");
      $finish;
    end
  end

  // ---------------- sequencing ----------------
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // block is idle once all pixels are in and every expected result is out
  task automatic drain();
    do @(posedge clk); while (pixel_q.size() > 0 || in_valid || filtered_q.size() > 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one frame geometry; black and white on two of every five pixels, frame start on the first and at random
  task automatic run_phase(input int w, input int h, input int r, input int n,
                           input int mode, input bit mid_pause);
    pixel_t p;
    idle_mode = 0;
    write_reg(rwmf_pkg::REG_WIDTH, 16'(w));
    write_reg(rwmf_pkg::REG_HEIGHT, 16'(h));
    write_reg(rwmf_pkg::REG_RADIUS, 16'(r));
    idle_mode = mode;
    for (int k = 0; k < n; k++) begin
      case (k % 5)
        0: {p.r, p.g, p.b} = 24'h000000;
        1: {p.r, p.g, p.b} = 24'hFFFFFF;
        default: {p.r, p.g, p.b} = 24'($urandom);
      endcase
      p.fs = (k == 0) || ($urandom_range(99) < 2);
      pixel_q.push_back(p);
      if (mid_pause && k == n / 2) drain();
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    // directed: 3x3 single median, radius zero, narrow image, zero width/height
    run_phase(3, 3, 1, 9, 0, 0);
    run_phase(4, 2, 0, 5, 0, 0);
    run_phase(2, 5, 1, 6, 0, 0);
    run_phase(0, 0, 2, 3, 0, 0);
    // random frames across idling styles and geometries
    run_phase(8, 6, 1, 120, 0, 1);
    run_phase(7, 7, 3, 60, 1, 0);
    hold_req = 1;
    run_phase(12, 9, 2, 110, 2, 0);
    run_phase(10, 8, 3, 60, 3, 1);
    run_phase(4095, 1, 1, 40, 1, 0);
    run_phase(5, 65535, 1, 80, 2, 0);
    run_phase(9, 9, 0, 60, 3, 0);
    run_phase(16, 7, 2, 90, 0, 0);
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d pixels, %0d output pixels (%0d window medians)",
             n_pixels, n_results, n_medians);
    $display("radius 0..3, widths 0..4095, heights 0..65535, stalls on both sides");
    if (errors == 0 && filtered_q.size() == 0)
      $display("[rgb_window_median_filter] OK");
    else
      $display("[rgb_window_median_filter] ERROR");
    $finish;
  end

endmodule
`default_nettype wire
